### hdl/kbyte_run_length_compressor_unit_macros.svh
// Assertion macros used by the checker file of the run-length compressor.
`ifndef KBYTE_RUN_LENGTH_COMPRESSOR_UNIT_MACROS_SVH
`define KBYTE_RUN_LENGTH_COMPRESSOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define KBRLC_ASSERT_IMP(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define KBRLC_ASSERT_NXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
else $error(msg);

`endif

### hdl/kbrlc_pkg.sv
// Package of the run-length compressor: sizes, codes, memory request type, helpers.
package kbrlc_pkg;

	localparam int MAX_CHUNK  = 16;
	localparam int IDX_W      = (MAX_CHUNK > 1) ? $clog2(MAX_CHUNK) : 1;
	localparam int FILL_W     = $clog2(MAX_CHUNK + 1);
	localparam int LEN_W      = 5;
	localparam int MEM_DEPTH  = 2 * MAX_CHUNK;
	localparam int MEM_AW     = IDX_W + 1;

	localparam logic [7:0] COUNT_MAX = 8'd255;
	localparam logic [7:0] COUNT_ONE = 8'd1;

	// one write and one read per cycle into the two-bank pattern/chunk memory
	typedef struct packed {
		logic              we;
		logic [MEM_AW-1:0] waddr;
		logic [7:0]        wdata;
		logic              re;
		logic [MEM_AW-1:0] raddr;
	} mem_req_t;

	// chunk length as used: 0 reads as 1, above MAX_CHUNK saturates
	function automatic logic [FILL_W-1:0] eff_len(input logic [LEN_W-1:0] v);
		logic [FILL_W-1:0] r;
		if (v == '0) begin
			r = FILL_W'(1);
		end else if (int'(v) > MAX_CHUNK) begin
			r = FILL_W'(MAX_CHUNK);
		end else begin
			r = FILL_W'(v);
		end
		return r;
	endfunction

endpackage

### hdl/kbrlc_if.sv
// Handshake channels of the run-length compressor: input bytes, output bytes, config.
interface kbrlc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;
	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface kbrlc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;
	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

interface kbrlc_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [kbrlc_pkg::LEN_W-1:0] chunk_len;
	modport source (output valid, output chunk_len, input ready);
	modport sink (input valid, input chunk_len, output ready);
endinterface

### hdl/kbrlc_ram.sv
// Two-bank byte memory holding the run pattern and the chunk being gathered.
module kbrlc_ram (
	input  logic                clk,
	input  kbrlc_pkg::mem_req_t req,
	output logic [7:0]          rdata
);

	logic [7:0] mem [kbrlc_pkg::MEM_DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hdl/kbrlc_ctrl.sv
// Sequencer of the run-length compressor: chunk compare, run count, emission.
module kbrlc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	kbrlc_in_if.sink            din,
	kbrlc_out_if.source         dout,
	kbrlc_cfg_if.sink           cfg,
	output kbrlc_pkg::mem_req_t mem_req,
	input  logic [7:0]          mem_rdata
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CHECK = 4'b0010,
		ST_HDR   = 4'b0100,
		ST_DATA  = 4'b1000
	} state_t;

	typedef enum logic {
		SEG_RUN  = 1'b0,
		SEG_PART = 1'b1
	} seg_t;

	state_t state_q;
	seg_t   seg_q;

	logic [kbrlc_pkg::LEN_W-1:0]  chunk_len_q;
	logic [kbrlc_pkg::FILL_W-1:0] k;
	logic [kbrlc_pkg::FILL_W-1:0] fill_q;
	logic [7:0]                   count_q;
	logic                         have_q;
	logic                         match_q;
	logic                         bank_q;   // bank holding the pattern; the other gathers
	logic                         swap_pend_q;
	logic                         more_run_q;
	logic                         part_pend_q;
	logic [kbrlc_pkg::FILL_W-1:0] idx_q;
	logic                         out_valid_q;
	logic [7:0]                   out_byte_q;
	logic                         out_last_q;

	logic [7:0]                   byte_s1;
	logic                         last_s1;
	logic [kbrlc_pkg::IDX_W-1:0]  pos_s1;

	logic                         in_acc;
	logic [kbrlc_pkg::FILL_W-1:0] pos_full;
	logic [kbrlc_pkg::IDX_W-1:0]  pos_in;
	logic                         out_free;
	logic                         new_match;
	logic [kbrlc_pkg::FILL_W-1:0] new_fill;
	logic                         full;
	logic                         bump;
	logic                         emit_old;
	logic [kbrlc_pkg::FILL_W-1:0] seg_len;
	logic                         seg_bank;
	logic                         seg_end;
	logic                         seg_final;
	logic                         load_hdr;
	logic                         load_data;

	assign k         = kbrlc_pkg::eff_len(chunk_len_q);
	assign din.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign in_acc    = din.valid && din.ready;

	assign pos_full  = (fill_q >= k) ? (k - kbrlc_pkg::FILL_W'(1)) : fill_q;
	assign pos_in    = pos_full[kbrlc_pkg::IDX_W-1:0];
	assign out_free  = !out_valid_q || dout.ready;

	assign new_match = match_q && have_q && (mem_rdata == byte_s1);
	assign new_fill  = kbrlc_pkg::FILL_W'(pos_s1) + kbrlc_pkg::FILL_W'(1);
	assign full      = (new_fill >= k);
	assign bump      = have_q && new_match && (count_q != kbrlc_pkg::COUNT_MAX);
	assign emit_old  = full && have_q && !bump;

	assign seg_len   = (seg_q == SEG_RUN) ? k : fill_q;
	assign seg_bank  = (seg_q == SEG_RUN) ? bank_q : ~bank_q;
	assign seg_end   = (idx_q == seg_len);
	assign seg_final = (seg_q == SEG_PART) || (!more_run_q && !part_pend_q);

	assign load_hdr  = (state_q == ST_HDR) && out_free;
	assign load_data = (state_q == ST_DATA) && out_free;

	// memory port: byte write + pattern read on accept, one read per emitted pattern byte
	always_comb begin
		mem_req = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = {~bank_q, pos_in};
					mem_req.wdata = din.in_byte;
					mem_req.re    = 1'b1;
					mem_req.raddr = {bank_q, pos_in};
				end
			end
			ST_HDR: begin
				if (out_free) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = {seg_bank, kbrlc_pkg::IDX_W'(0)};
				end
			end
			ST_DATA: begin
				if (out_free && !seg_end) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = {seg_bank, idx_q[kbrlc_pkg::IDX_W-1:0]};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seg_q       <= SEG_RUN;
			chunk_len_q <= kbrlc_pkg::LEN_W'(1);
			fill_q      <= '0;
			count_q     <= '0;
			have_q      <= 1'b0;
			match_q     <= 1'b1;
			bank_q      <= 1'b0;
			swap_pend_q <= 1'b0;
			more_run_q  <= 1'b0;
			part_pend_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_hdr || load_data) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (full) begin
						fill_q  <= '0;
						match_q <= 1'b1;
						if (!emit_old) begin
							if (!have_q) begin
								bank_q  <= ~bank_q;
								count_q <= kbrlc_pkg::COUNT_ONE;
								have_q  <= 1'b1;
							end else begin
								count_q <= count_q + 8'd1;
							end
						end
					end else begin
						fill_q  <= new_fill;
						match_q <= new_match;
					end
					swap_pend_q <= emit_old;
					if (emit_old) begin
						// old run goes out first; chunk takes over afterwards
						seg_q       <= SEG_RUN;
						more_run_q  <= last_s1;
						part_pend_q <= 1'b0;
						state_q     <= ST_HDR;
					end else if (last_s1 && (have_q || full)) begin
						seg_q       <= SEG_RUN;
						more_run_q  <= 1'b0;
						part_pend_q <= !full;
						state_q     <= ST_HDR;
					end else if (last_s1) begin
						seg_q       <= SEG_PART;
						more_run_q  <= 1'b0;
						part_pend_q <= 1'b0;
						state_q     <= ST_HDR;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_HDR: begin
					if (out_free) begin
						idx_q   <= kbrlc_pkg::FILL_W'(1);
						state_q <= ST_DATA;
					end
				end
				ST_DATA: begin
					if (out_free) begin
						if (!seg_end) begin
							idx_q <= idx_q + kbrlc_pkg::FILL_W'(1);
						end else begin
							if (swap_pend_q) begin
								bank_q      <= ~bank_q;
								count_q     <= kbrlc_pkg::COUNT_ONE;
								swap_pend_q <= 1'b0;
							end
							if (more_run_q) begin
								seg_q      <= SEG_RUN;
								more_run_q <= 1'b0;
								state_q    <= ST_HDR;
							end else if (part_pend_q) begin
								seg_q       <= SEG_PART;
								part_pend_q <= 1'b0;
								state_q     <= ST_HDR;
							end else begin
								state_q <= ST_IDLE;
								if (last_s1) begin
									fill_q  <= '0;
									count_q <= '0;
									have_q  <= 1'b0;
									match_q <= 1'b1;
								end
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// new chunk length drops the stream in progress
			if (cfg.valid) begin
				chunk_len_q <= cfg.chunk_len;
				fill_q      <= '0;
				count_q     <= '0;
				have_q      <= 1'b0;
				match_q     <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= din.in_byte;
			last_s1 <= din.in_last;
			pos_s1  <= pos_in;
		end
		if (load_hdr) begin
			out_byte_q <= (seg_q == SEG_RUN) ? count_q : kbrlc_pkg::COUNT_ONE;
			out_last_q <= 1'b0;
		end else if (load_data) begin
			out_byte_q <= mem_rdata;
			out_last_q <= seg_end && seg_final;
		end
	end

	assign dout.valid    = out_valid_q;
	assign dout.out_byte = out_byte_q;
	assign dout.out_last = out_last_q;

endmodule

### hdl/kbyte_run_length_compressor_unit.sv
// Top level of the multi-byte run-length compressor.
//
//  channel | dir | payload              | request taken when
//  --------+-----+----------------------+------------------------------
//  din     | in  | in_byte[7:0] in_last | din.valid && din.ready
//  dout    | out | out_byte[7:0] out_last| dout.valid && dout.ready
//  cfg     | in  | chunk_len[4:0]       | cfg.valid (ready held high)
//
// Each input request is accepted (byte written to the chunk bank, pattern byte
// read) and then compared against the pattern memory's registered read, with
// din.ready low meanwhile. A run goes out as a count byte, then one pattern byte
// per cycle unless dout stalls, off the single memory read port; a partial chunk likewise.
// A stalled dout holds the sequencer; din stays low until emission is done.
// Reset clears the control state only; the memory needs no clearing pass.
module kbyte_run_length_compressor_unit (
	input logic         clk,
	input logic         arst_n,
	kbrlc_in_if.sink    din,
	kbrlc_out_if.source dout,
	kbrlc_cfg_if.sink   cfg
);

	// memory request from the sequencer and its registered read data
	kbrlc_pkg::mem_req_t mem_req;
	logic [7:0]          mem_rdata;

	// sequencer: chunk compare, run count, bank swap instead of copying the chunk
	kbrlc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.din       (din),
		.dout      (dout),
		.cfg       (cfg),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	// two banks of MAX_CHUNK bytes: pattern in one, gathered chunk in the other
	kbrlc_ram u_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

endmodule

### hdl/kbrlc_checker.sv
// Port-level checks of the run-length compressor and their bind.
`include "kbyte_run_length_compressor_unit_macros.svh"

module kbrlc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_last
);

	`KBRLC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_last), "stalled output changed")
	`KBRLC_ASSERT_IMP(a_busy_mid_run, out_valid && !out_last, !in_ready, "input taken mid emission")
	`KBRLC_ASSERT_NXT(a_single_item, in_valid && in_ready, !in_ready, "second request taken during compare")

endmodule

bind kbyte_run_length_compressor_unit kbrlc_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (din.valid),
	.in_ready  (din.ready),
	.out_valid (dout.valid),
	.out_ready (dout.ready),
	.out_byte  (dout.out_byte),
	.out_last  (dout.out_last)
);
